### hdl/qws_pkg.sv
`default_nettype none

package qws_pkg;

    // Slot counts of the delimiter and quote registers.
    localparam int DELIM_SLOTS = 4;
    localparam int QUOTE_SLOTS = 4;

    // Number of byte slots that one 32-bit register can hold.
    localparam int REG_SLOTS = 4;

    // Widths of the fields.
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 2;
    localparam int TOTAL_W = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // One input can cause up to three results.
    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W   = 2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_CHAR     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WORD_END = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEXT_END = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd2;

    // Reset values: space, tab and newline; double and single quote; backslash.
    localparam logic [CFG_W-1:0]  DELIMS_RST = 32'h000A_0920;
    localparam logic [CFG_W-1:0]  QUOTES_RST = 32'h0000_2722;
    localparam logic [CHAR_W-1:0] ESCAPE_RST = 8'h5C;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic [CFG_W-1:0]  delims;
        logic [CFG_W-1:0]  quotes;
        logic [CHAR_W-1:0] esc;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAR_W-1:0]  ch;
        logic [TOTAL_W-1:0] total;
    } event_t;

    typedef event_t [MAX_RESULTS-1:0] ev_list_t;

    // True when a nonzero character sits in one of the first n slots.
    // Slots past the end of the register are unused.
    function automatic logic in_slots(logic [CFG_W-1:0] slots, int n,
                                      logic [CHAR_W-1:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < REG_SLOTS; i++)
        begin
            if (i < n && c != '0 && slots[CHAR_W*i +: CHAR_W] == c)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

### hdl/qws_cfg_regs.sv
`default_nettype none

module qws_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [qws_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [qws_pkg::CFG_W-1:0]     wr_data,
    output qws_pkg::cfg_t                      cfg
);
    import qws_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write request; unknown indexes leave everything alone.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_DELIMS: cfg_next.delims = wr_data;
                CFG_QUOTES: cfg_next.quotes = wr_data;
                CFG_ESCAPE: cfg_next.esc    = wr_data[CHAR_W-1:0];
                default:    cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{delims: DELIMS_RST, quotes: QUOTES_RST, esc: ESCAPE_RST};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hdl/qws_decode.sv
`default_nettype none

module qws_decode (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       commit,
    input  wire logic [qws_pkg::CHAR_W-1:0] text_char,
    input  wire logic                       end_of_text,
    input  wire qws_pkg::cfg_t              cfg,
    output qws_pkg::ev_list_t               events,
    output logic [qws_pkg::RES_CNT_W-1:0]   event_cnt
);
    import qws_pkg::*;

    logic [CHAR_W-1:0]  open_quote_reg;
    logic [CHAR_W-1:0]  open_quote_next;
    logic               esc_pend_reg;
    logic               esc_pend_next;
    logic               skip_reg;
    logic               skip_next;
    logic               word_open_reg;
    logic               word_open_next;
    logic [TOTAL_W-1:0] count_reg;
    logic [TOTAL_W-1:0] count_next;

    logic               is_delim;
    logic               is_quote;
    logic               is_esc;
    logic               stop;
    ev_list_t           ev;
    logic [RES_CNT_W-1:0] n;

    assign is_delim = in_slots(cfg.delims, DELIM_SLOTS, text_char);
    assign is_quote = in_slots(cfg.quotes, QUOTE_SLOTS, text_char);
    assign is_esc   = (text_char == cfg.esc);

    // Work out the results of the held character and the state after it.
    always_comb
    begin
        open_quote_next = open_quote_reg;
        esc_pend_next   = esc_pend_reg;
        skip_next       = skip_reg;
        word_open_next  = word_open_reg;
        count_next      = count_reg;
        ev              = '0;
        n               = '0;
        stop            = 1'b0;

        if (end_of_text)
        begin
            // Flush a dangling escape and the open word, then report the count.
            if (esc_pend_reg)
            begin
                ev[n] = '{kind: KIND_CHAR, ch: cfg.esc, total: '0};
                n = n + 2'd1;
            end
            if (word_open_reg)
            begin
                ev[n] = '{kind: KIND_WORD_END, ch: '0, total: '0};
                n = n + 2'd1;
            end
            ev[n] = '{kind: KIND_TEXT_END, ch: '0, total: count_reg};
            n = n + 2'd1;
            open_quote_next = '0;
            esc_pend_next   = 1'b0;
            skip_next       = 1'b1;
            word_open_next  = 1'b0;
            count_next      = '0;
        end
        else
        begin
            // A non-delimiter after a delimiter run starts a new word.
            if (skip_reg)
            begin
                if (is_delim)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    skip_next = 1'b0;
                    if (word_open_reg)
                    begin
                        ev[n] = '{kind: KIND_WORD_END, ch: '0, total: '0};
                        n = n + 2'd1;
                    end
                    word_open_next = 1'b1;
                    if (count_reg != TOTAL_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end

            if (!stop)
            begin
                if (open_quote_reg != '0)
                begin
                    // Inside quotes only the open quote closes the group.
                    if (esc_pend_reg)
                    begin
                        if (text_char != open_quote_reg && !is_esc)
                        begin
                            ev[n] = '{kind: KIND_CHAR, ch: cfg.esc, total: '0};
                            n = n + 2'd1;
                        end
                        ev[n] = '{kind: KIND_CHAR, ch: text_char, total: '0};
                        n = n + 2'd1;
                        esc_pend_next = 1'b0;
                    end
                    else if (text_char == open_quote_reg)
                    begin
                        open_quote_next = '0;
                    end
                    else if (is_esc)
                    begin
                        esc_pend_next = 1'b1;
                    end
                    else
                    begin
                        ev[n] = '{kind: KIND_CHAR, ch: text_char, total: '0};
                        n = n + 2'd1;
                    end
                end
                else
                begin
                    // Outside quotes: quote first, then delimiter, then escape.
                    if (esc_pend_reg)
                    begin
                        if (!is_esc && !is_quote && !is_delim)
                        begin
                            ev[n] = '{kind: KIND_CHAR, ch: cfg.esc, total: '0};
                            n = n + 2'd1;
                        end
                        ev[n] = '{kind: KIND_CHAR, ch: text_char, total: '0};
                        n = n + 2'd1;
                        esc_pend_next = 1'b0;
                    end
                    else if (is_quote)
                    begin
                        open_quote_next = text_char;
                    end
                    else if (is_delim)
                    begin
                        skip_next = 1'b1;
                    end
                    else if (is_esc)
                    begin
                        esc_pend_next = 1'b1;
                    end
                    else
                    begin
                        ev[n] = '{kind: KIND_CHAR, ch: text_char, total: '0};
                        n = n + 2'd1;
                    end
                end
            end
        end
    end

    // Scanner state moves only when the held request goes to the result buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_quote_reg <= '0;
            esc_pend_reg   <= 1'b0;
            skip_reg       <= 1'b1;
            word_open_reg  <= 1'b0;
            count_reg      <= '0;
        end
        else if (commit)
        begin
            open_quote_reg <= open_quote_next;
            esc_pend_reg   <= esc_pend_next;
            skip_reg       <= skip_next;
            word_open_reg  <= word_open_next;
            count_reg      <= count_next;
        end
    end

    assign events    = ev;
    assign event_cnt = n;

endmodule

`default_nettype wire

### hdl/qws_out_buf.sv
`default_nettype none

module qws_out_buf (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire qws_pkg::ev_list_t             events,
    input  wire logic [qws_pkg::RES_CNT_W-1:0] event_cnt,
    output logic                               drained,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [qws_pkg::CHAR_W+qws_pkg::TOTAL_W-1:0] m_tdata,
    output logic [qws_pkg::KIND_W-1:0]         m_tuser,
    output logic                               m_tlast
);
    import qws_pkg::*;

    ev_list_t             ev_reg;
    logic [RES_CNT_W-1:0] cnt_reg;
    logic [RES_CNT_W-1:0] idx_reg;
    event_t               cur;

    // The buffer frees up once its last result is taken in this cycle.
    assign drained = (cnt_reg == '0) || (cnt_reg == 2'd1 && m_tready);

    // Results of one request are held together and sent one per cycle while the sink is ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= event_cnt;
            idx_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            cnt_reg <= cnt_reg - 2'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ev_reg <= events;
        end
    end

    assign cur      = ev_reg[idx_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {cur.total, cur.ch};
    assign m_tuser  = cur.kind;
    assign m_tlast  = (cnt_reg == 2'd1);

endmodule

`default_nettype wire

### hdl/quoted_word_splitter.sv
// Path: an accepted character waits in the input register, where it is decoded; its
// results go to the result buffer once that buffer drains, and m_tvalid comes from there.
// Throughput: one character per cycle while each has at most one result and the sink is
// ready; a character with several results stalls input until the buffer drains.
// Reset: rst_n is asynchronous and active low; it empties both stages, restores the
// default delimiters, quotes and escape, and starts a fresh string.
`default_nettype none

module quoted_word_splitter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // s_tdata: text_char[7:0]
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,
    input  wire logic                          s_tlast,
    // m_tdata: word_char[7:0], word_total[23:8]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [23:0]                        m_tdata,
    // m_tuser: event_kind[1:0]
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [qws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [qws_pkg::CFG_W-1:0]     cfg_data
);
    import qws_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_eot_reg;
    logic              s_accept;
    logic              advance;
    logic              drained;
    cfg_t              cfg;
    ev_list_t          events;
    logic [RES_CNT_W-1:0] event_cnt;

    assign cfg_ready = 1'b1;

    qws_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Input register: a new request enters while it is empty or whenever the held one moves on.
    assign advance  = in_valid_reg && drained;
    assign s_tready = !in_valid_reg || drained;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_char_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    qws_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .commit      (advance),
        .text_char   (in_char_reg),
        .end_of_text (in_eot_reg),
        .cfg         (cfg),
        .events      (events),
        .event_cnt   (event_cnt)
    );

    qws_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .events    (events),
        .event_cnt (event_cnt),
        .drained   (drained),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

### hdl/qws_checker.sv
`default_nettype none

module qws_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [23:0]                   m_tdata,
    input  wire logic [1:0]                    m_tuser,
    input  wire logic                          m_tlast
);
    import qws_pkg::*;

    // A result held back by the sink keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result changed");

    // The end-of-string result always closes the run of its request.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_TEXT_END |-> m_tlast)
        else $error("end-of-string result without tlast");

    // Only end-of-string results carry a word count.
    a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_TEXT_END |-> m_tdata[23:8] == '0)
        else $error("word count on a non-final result");

    // Word-end and end-of-string results carry no character.
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_WORD_END || m_tuser == KIND_TEXT_END)
        |-> m_tdata[7:0] == '0)
        else $error("character on a marker result");

    // The input side is never refused while no result is pending.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !$past(s_tvalid && s_tready) |-> s_tready)
        else $error("input stalled with an empty pipeline");

endmodule

bind quoted_word_splitter qws_checker u_qws_checker (.*);

`default_nettype wire
